### rtl/core/trapezoid_profile_generator_assert.svh
// Assertion macros for the trapezoid profile generator.
// Depends on nothing; included by the top level.
`ifndef TRAPEZOID_PROFILE_GENERATOR_ASSERT_SVH
`define TRAPEZOID_PROFILE_GENERATOR_ASSERT_SVH
`define TPG_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define TPG_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

### rtl/core/tpg_pkg.sv
// Package for the trapezoid profile generator: payload types, codes, helpers.
// Depends on nothing.
package tpg_pkg;
  localparam int FRAC_BITS = 16;
  localparam logic [24:0] FULL_TURN = 25'(360 << FRAC_BITS);
  localparam logic [24:0] HALF_TURN = 25'(180 << FRAC_BITS);
  localparam logic signed [63:0] SAT_BIG = 64'sd1 <<< 62;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [1:0] REG_MAX_VEL = 2'd0;
  localparam logic [1:0] REG_MAX_ACC = 2'd1;
  localparam logic [1:0] REG_TICK    = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [30:0] distance_goal;
    logic [30:0] speed_start;
    logic [30:0] speed_end;
    logic [24:0] heading_begin;
    logic [24:0] heading_finish;
    logic        go_backward;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] acceleration;
    logic [24:0]        heading_out;
    logic               last;
  } out_item_t;

  typedef enum logic [1:0] {
    UOP_MUL,
    UOP_DIV,
    UOP_SQRT
  } uop_t;

  typedef struct packed {
    logic               start;
    uop_t               op;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } unit_req_t;

  typedef enum logic [5:0] {
    S_IDLE,
    S_L_SQ0, S_L_SQ1, S_L_SQ2, S_L_SQRT, S_L_VP,
    S_L_TUP, S_L_XUP, S_L_TDN, S_L_XDN, S_L_TCR, S_L_DONE,
    S_T_V, S_T_A, S_T_X, S_T_H0, S_T_H1, S_T_OUT,
    S_OUT
  } state_t;

  function automatic logic signed [63:0] sat32(input logic signed [63:0] a);
    if (a > 64'sd2147483647) return 64'sd2147483647;
    if (a < -64'sd2147483648) return -64'sd2147483648;
    return a;
  endfunction

  function automatic logic [24:0] wrap_in(input logic [24:0] h);
    return (h >= FULL_TURN) ? h - FULL_TURN : h;
  endfunction
endpackage

### rtl/core/tpg_arith.sv
// Shared arithmetic unit: saturating Q multiply (multi-cycle partial
// products), restoring divide and bit-pair square root. Depends on tpg_pkg.
module tpg_arith (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tpg_pkg::unit_req_t          req,
  output logic                        done,
  output logic signed [63:0]          res
);
  import tpg_pkg::*;

  logic               busy_r, busy_nxt;
  uop_t               op_r, op_nxt;
  logic [6:0]         cnt_r, cnt_nxt;
  logic [63:0]        x_r, x_nxt;
  logic [63:0]        y_r, y_nxt;
  logic [127:0]       acc_r, acc_nxt;
  logic [63:0]        q_r, q_nxt;
  logic               neg_r, neg_nxt;
  logic               done_r, done_nxt;
  logic signed [63:0] res_r, res_nxt;

  logic [63:0] ua, ub, un;
  logic [31:0] xs;
  logic [15:0] ys;
  logic [6:0]  msh;
  logic [47:0] pp;
  logic [64:0] trial;
  logic [63:0] sqb, sqt, mres;

  always_comb begin
    ua = req.a[63] ? 64'(-req.a) : 64'(req.a);
    ub = req.b[63] ? 64'(-req.b) : 64'(req.b);
    un = (ua > (64'd1 << 38)) ? (64'd1 << 38) : ua;
    busy_nxt = busy_r;
    op_nxt = op_r;
    cnt_nxt = cnt_r;
    x_nxt = x_r;
    y_nxt = y_r;
    acc_nxt = acc_r;
    q_nxt = q_r;
    neg_nxt = neg_r;
    done_nxt = 1'b0;
    res_nxt = res_r;
    xs = cnt_r[2] ? x_r[63:32] : x_r[31:0];
    ys = y_r[{cnt_r[1:0], 4'd0} +: 16];
    msh = 7'({cnt_r[2], 5'd0}) + 7'({cnt_r[1:0], 4'd0});
    pp = xs * ys;
    trial = 65'(acc_r[63:0]) - 65'(y_r);
    sqb = 64'd1 << {cnt_r[5:0], 1'b0};
    sqt = q_r + sqb;
    mres = 64'(acc_r >> FRAC_BITS);
    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt = req.op;
      neg_nxt = req.a[63] ^ req.b[63];
      acc_nxt = '0;
      q_nxt = '0;
      unique case (req.op)
        UOP_MUL: begin
          x_nxt = ua;
          y_nxt = ub;
          cnt_nxt = 7'd0;
        end
        UOP_DIV: begin
          x_nxt = un << FRAC_BITS;
          y_nxt = ub;
          cnt_nxt = 7'd63;
        end
        default: begin
          x_nxt = 64'(req.a);
          y_nxt = '0;
          neg_nxt = 1'b0;
          cnt_nxt = 7'd31;
        end
      endcase
    end else if (busy_r) begin
      unique case (op_r)
        UOP_MUL: begin
          if (cnt_r[3]) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
            if (acc_r[127:64] != 64'd0 || mres > 64'(SAT_BIG))
              res_nxt = neg_r ? -SAT_BIG : SAT_BIG;
            else
              res_nxt = neg_r ? -$signed(mres) : $signed(mres);
          end else begin
            acc_nxt = acc_r + (128'(pp) << msh);
            cnt_nxt = cnt_r + 7'd1;
          end
        end
        UOP_DIV: begin
          if (y_r == 64'd0) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
            res_nxt = '0;
          end else begin
            acc_nxt[63:0] = {acc_r[62:0], x_r[cnt_r[5:0]]};
            trial = 65'({acc_r[62:0], x_r[cnt_r[5:0]]}) - 65'(y_r);
            q_nxt = {q_r[62:0], ~trial[64]};
            if (!trial[64]) acc_nxt[63:0] = trial[63:0];
            cnt_nxt = cnt_r - 7'd1;
            if (cnt_r == 7'd0) begin
              busy_nxt = 1'b0;
              done_nxt = 1'b1;
              res_nxt = neg_r ? -$signed({q_nxt}) : $signed(q_nxt);
            end
          end
        end
        default: begin
          if (x_r >= sqt) begin
            x_nxt = x_r - sqt;
            q_nxt = (q_r >> 1) + sqb;
          end else begin
            q_nxt = q_r >> 1;
          end
          cnt_nxt = cnt_r - 7'd1;
          if (cnt_r == 7'd0) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
            res_nxt = $signed(q_nxt);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r <= UOP_MUL;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r <= op_nxt;
      cnt_r <= cnt_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    acc_r <= acc_nxt;
    q_r <= q_nxt;
    neg_r <= neg_nxt;
    res_r <= res_nxt;
  end

  assign done = done_r;
  assign res = res_r;
endmodule

### rtl/core/trapezoid_profile_generator.sv
// Top level of the trapezoid profile generator: sequencer and move state.
// Depends on tpg_pkg, tpg_arith and trapezoid_profile_generator_assert.svh.
//
//   channel | direction | handshake       | payload
//   in      | input     | in_valid/ready  | tpg_pkg::in_item_t
//   out     | output    | out_valid/ready | tpg_pkg::out_item_t
//   cfg     | input     | cfg_we          | cfg_index, cfg_data
//
// A load item uses three 31x31 products for the root argument, a 32-step
// root, three 64-step divides and two multiplies. A tick uses up to three
// multiplies and two divides; the closing tick uses no unit op. Reset is
// synchronous; the result register holds while out_ready is low and no item
// is taken until it is delivered.
module trapezoid_profile_generator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tpg_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tpg_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [30:0]         cfg_data
);
  import tpg_pkg::*;

  state_t state_r, state_nxt;
  logic [30:0] vmax_r, amax_r;
  logic [15:0] tick_r;
  logic active_r, active_nxt, back_r, back_nxt;
  logic signed [63:0] v0_r, v0_nxt, vp_r, vp_nxt, tae_r, tae_nxt, tce_r, tce_nxt;
  logic signed [63:0] tt_r, tt_nxt, el_r, el_nxt, tr_r, tr_nxt, sp_r, sp_nxt;
  logic signed [63:0] t0_r, t0_nxt, t1_r, t1_nxt, t2_r, t2_nxt, d_r, d_nxt, v1_r, v1_nxt;
  logic [24:0] hb_r, hb_nxt, ht_r, ht_nxt;
  logic signed [25:0] hs_r, hs_nxt;
  logic issued_r, issued_nxt;
  out_item_t ob_r, ob_nxt;
  logic ov_r, ov_nxt;
  unit_req_t req;
  logic udone;
  logic signed [63:0] ures;
  logic [24:0] hsw, hew;
  logic signed [25:0] span;
  logic signed [63:0] hsum, vcur;
  logic [30:0] mul_a, mul_b;
  logic [61:0] mul_p;

  tpg_arith u_arith (.clk(clk), .rst_n(rst_n), .req(req), .done(udone), .res(ures));

  function automatic logic signed [31:0] outneg(input logic signed [63:0] a, input logic b);
    return 32'(b ? sat32(-a) : a);
  endfunction

  always_comb begin
    mul_a = d_r[30:0];
    mul_b = amax_r;
    if (state_r == S_L_SQ1) begin
      mul_a = v0_r[30:0];
      mul_b = v0_r[30:0];
    end else if (state_r == S_L_SQ2) begin
      mul_a = v1_r[30:0];
      mul_b = v1_r[30:0];
    end
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    state_nxt = state_r;
    active_nxt = active_r; back_nxt = back_r;
    v0_nxt = v0_r; vp_nxt = vp_r; tae_nxt = tae_r; tce_nxt = tce_r; tt_nxt = tt_r;
    el_nxt = el_r; tr_nxt = tr_r; sp_nxt = sp_r;
    t0_nxt = t0_r; t1_nxt = t1_r; t2_nxt = t2_r; d_nxt = d_r; v1_nxt = v1_r;
    hb_nxt = hb_r; ht_nxt = ht_r; hs_nxt = hs_r;
    ob_nxt = ob_r; ov_nxt = ov_r;
    issued_nxt = 1'b0;
    req = '{start: 1'b0, op: UOP_MUL, a: '0, b: '0};
    in_ready = (state_r == S_IDLE) && !ov_r;
    hsw = wrap_in(in_data.heading_begin);
    hew = wrap_in(in_data.heading_finish);
    span = $signed({1'b0, hew}) - $signed({1'b0, hsw});
    if (span > $signed({1'b0, HALF_TURN})) span = span - $signed({1'b0, FULL_TURN});
    else if (span <= -$signed({1'b0, HALF_TURN})) span = span + $signed({1'b0, FULL_TURN});
    hsum = 64'(hb_r) + ures;
    vcur = t0_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    // issue at most one unit op per state, advance on done where one is pending
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_data.kind == KIND_LOAD) begin
            d_nxt = 64'(in_data.distance_goal);
            v0_nxt = 64'(in_data.speed_start);
            v1_nxt = 64'(in_data.speed_end);
            hb_nxt = hsw; ht_nxt = hew; hs_nxt = span;
            back_nxt = in_data.go_backward;
            state_nxt = S_L_SQ0;
          end else if (active_r) begin
            state_nxt = (el_r <= tt_r) ? S_T_V : S_OUT;
          end
        end
      end
      S_L_SQ0: begin
        t0_nxt = 64'(mul_p);
        state_nxt = S_L_SQ1;
      end
      S_L_SQ1: begin
        t1_nxt = t0_r + 64'(mul_p >> 1);
        state_nxt = S_L_SQ2;
      end
      S_L_SQ2: begin
        req = '{start: 1'b1, op: UOP_SQRT, a: t1_r + 64'(mul_p >> 1), b: '0};
        state_nxt = S_L_SQRT;
      end
      S_L_SQRT: if (udone) begin
        vp_nxt = (ures < 64'(vmax_r)) ? ures : 64'(vmax_r);
        state_nxt = S_L_VP;
      end
      S_L_VP: begin
        req = '{start: 1'b1, op: UOP_DIV, a: vp_r - v0_r, b: 64'(amax_r)};
        state_nxt = S_L_TUP;
      end
      S_L_TUP: if (udone) begin
        tae_nxt = sat32(ures);
        req = '{start: 1'b1, op: UOP_MUL, a: vp_r + v0_r, b: sat32(ures)};
        state_nxt = S_L_XUP;
      end
      S_L_XUP: if (udone) begin
        t1_nxt = sat32(ures / 2);
        req = '{start: 1'b1, op: UOP_DIV, a: vp_r - v1_r, b: 64'(amax_r)};
        state_nxt = S_L_TDN;
      end
      S_L_TDN: if (udone) begin
        t2_nxt = sat32(ures);
        req = '{start: 1'b1, op: UOP_MUL, a: vp_r + v1_r, b: sat32(ures)};
        state_nxt = S_L_XDN;
      end
      S_L_XDN: if (udone) begin
        req = '{start: 1'b1, op: UOP_DIV, a: d_r - t1_r - sat32(ures / 2), b: vp_r};
        state_nxt = S_L_TCR;
      end
      S_L_TCR: if (udone) begin
        tce_nxt = sat32(tae_r + sat32(ures));
        tt_nxt = sat32(tae_r + sat32(ures) + t2_r);
        state_nxt = S_L_DONE;
      end
      S_L_DONE: begin
        el_nxt = '0; tr_nxt = '0; sp_nxt = '0;
        active_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      S_T_V: begin
        if (!issued_r) begin
          issued_nxt = 1'b1;
          if (el_r <= tae_r) req = '{start: 1'b1, op: UOP_MUL, a: 64'(amax_r), b: el_r};
          else if (el_r > tce_r)
            req = '{start: 1'b1, op: UOP_MUL, a: 64'(amax_r), b: el_r - tce_r};
          else begin
            t0_nxt = sat32(vp_r);
            issued_nxt = 1'b0;
            state_nxt = S_T_A;
          end
        end else if (udone) begin
          t0_nxt = (el_r <= tae_r) ? sat32(v0_r + ures) : sat32(vp_r - ures);
          state_nxt = S_T_A;
        end else issued_nxt = 1'b1;
      end
      S_T_A: begin
        req = '{start: 1'b1, op: UOP_DIV, a: vcur - sp_r, b: 64'(tick_r)};
        state_nxt = S_T_X;
      end
      S_T_X: if (udone) begin
        t1_nxt = sat32(ures);
        req = '{start: 1'b1, op: UOP_MUL, a: vcur + sp_r, b: 64'(tick_r)};
        state_nxt = S_T_H0;
      end
      S_T_H0: if (udone) begin
        t2_nxt = sat32(tr_r + ures / 2);
        req = '{start: 1'b1, op: UOP_DIV, a: el_r, b: tt_r};
        state_nxt = S_T_H1;
      end
      S_T_H1: if (udone) begin
        req = '{start: 1'b1, op: UOP_MUL, a: 64'(hs_r), b: ures};
        state_nxt = S_T_OUT;
      end
      S_T_OUT: if (udone) begin
        ob_nxt.position = outneg(t2_r, back_r);
        ob_nxt.velocity = outneg(vcur, back_r);
        ob_nxt.acceleration = outneg(t1_r, back_r);
        if (hsum < 0) ob_nxt.heading_out = 25'(hsum + 64'(FULL_TURN));
        else if (hsum >= 64'(FULL_TURN)) ob_nxt.heading_out = 25'(hsum - 64'(FULL_TURN));
        else ob_nxt.heading_out = 25'(hsum);
        ob_nxt.last = 1'b0;
        ov_nxt = 1'b1;
        tr_nxt = t2_r;
        sp_nxt = vcur;
        el_nxt = sat32(el_r + 64'(tick_r));
        state_nxt = S_IDLE;
      end
      S_OUT: begin
        ob_nxt.position = outneg(tr_r, back_r);
        ob_nxt.velocity = outneg(sp_r, back_r);
        ob_nxt.acceleration = '0;
        ob_nxt.heading_out = ht_r;
        ob_nxt.last = 1'b1;
        ov_nxt = 1'b1;
        active_nxt = 1'b0;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
      issued_r <= 1'b0;
      active_r <= 1'b0;
      back_r <= 1'b0;
      vmax_r <= 31'd3932160;
      amax_r <= 31'd7864320;
      tick_r <= 16'd655;
      v0_r <= '0; vp_r <= '0; tae_r <= '0; tce_r <= '0; tt_r <= '0;
      el_r <= '0; tr_r <= '0; sp_r <= '0;
      hb_r <= '0; hs_r <= '0; ht_r <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
      issued_r <= issued_nxt;
      active_r <= active_nxt;
      back_r <= back_nxt;
      v0_r <= v0_nxt; vp_r <= vp_nxt; tae_r <= tae_nxt; tce_r <= tce_nxt; tt_r <= tt_nxt;
      el_r <= el_nxt; tr_r <= tr_nxt; sp_r <= sp_nxt;
      hb_r <= hb_nxt; hs_r <= hs_nxt; ht_r <= ht_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MAX_VEL: vmax_r <= cfg_data;
          REG_MAX_ACC: amax_r <= cfg_data;
          REG_TICK:    tick_r <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
    t0_r <= t0_nxt; t1_r <= t1_nxt; t2_r <= t2_nxt; d_r <= d_nxt; v1_r <= v1_nxt;
    ob_r <= ob_nxt;
  end

  assign out_valid = ov_r;
  assign out_data = ob_r;

`include "trapezoid_profile_generator_assert.svh"
  `TPG_ASSERT_IMP(a_busy_no_ready, state_r != S_IDLE, !in_ready)
  `TPG_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `TPG_ASSERT_IMP(a_last_idle, out_valid && out_data.last, !active_r)
endmodule
